### rtl/utf8_text_validator_top_macros.svh
// Assertion macros for the UTF-8 text validator checker.
// Used by utf8v_checker.sv; each macro expects clk and arst_n in scope.
`ifndef UTF8_TEXT_VALIDATOR_TOP_MACROS_SVH
`define UTF8_TEXT_VALIDATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8V_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utf8 validator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTF8V_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utf8 validator check failed");

`endif

### rtl/utf8v_pkg.sv
// Shared types, error codes and helpers for the UTF-8 text validator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package utf8v_pkg;

	// Error classes, in the encoding shown on error_kind.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NUL       = 3'd1;
	localparam logic [2:0] ERR_LEAD      = 3'd2;
	localparam logic [2:0] ERR_CONT      = 3'd3;
	localparam logic [2:0] ERR_TRUNC     = 3'd4;
	localparam logic [2:0] ERR_OVERLONG  = 3'd5;
	localparam logic [2:0] ERR_LARGE     = 3'd6;
	localparam logic [2:0] ERR_SURROGATE = 3'd7;

	// Minimum code point classes of an open sequence.
	localparam logic [1:0] CLS_NONE  = 2'd0;
	localparam logic [1:0] CLS_TWO   = 2'd1;
	localparam logic [1:0] CLS_THREE = 2'd2;
	localparam logic [1:0] CLS_FOUR  = 2'd3;

	localparam int CP_W = 21;

	localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

	// Decoder state carried between bytes of one buffer.
	typedef struct packed {
		logic [1:0]      pending;
		logic [CP_W-1:0] code;
		logic [1:0]      min_class;
		logic            err_seen;
		logic [2:0]      first_err;
	} dec_state_t;

	// Verdict for one buffer.
	typedef struct packed {
		logic       ok;
		logic [2:0] kind;
	} verdict_t;

	localparam dec_state_t STATE_RESET = '{
		pending:   2'd0,
		code:      '0,
		min_class: CLS_NONE,
		err_seen:  1'b0,
		first_err: ERR_NONE
	};

	// Smallest code point that a sequence of the given class may encode.
	function automatic logic [CP_W-1:0] class_minimum(input logic [1:0] cls);
		logic [CP_W-1:0] m;
		case (cls)
			CLS_TWO:   m = 21'h000080;
			CLS_THREE: m = 21'h000800;
			default:   m = 21'h010000;
		endcase
		return m;
	endfunction

endpackage

### rtl/utf8v_step.sv
// Per-byte decode: next decoder state and verdict from the current state and one byte.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps

module utf8v_step (
	input  utf8v_pkg::dec_state_t cur,
	input  logic [7:0]            data_byte,
	input  logic                  is_last,
	output utf8v_pkg::dec_state_t nxt,
	output utf8v_pkg::verdict_t   verdict
);

	utf8v_pkg::dec_state_t s;
	logic [utf8v_pkg::CP_W-1:0] cp;

	// Code point after shifting in a continuation byte.
	assign cp = {cur.code[utf8v_pkg::CP_W-7:0], data_byte[5:0]};

	// Byte update; every error is the first one, since a recorded error freezes the state.
	always_comb begin
		s = cur;
		if (!cur.err_seen) begin
			if (cur.pending == 2'd0) begin
				if (data_byte == 8'h00) begin
					s.err_seen  = 1'b1;
					s.first_err = utf8v_pkg::ERR_NUL;
				end else if (data_byte < 8'h80) begin
					s = cur;
				end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
					s.code      = {16'd0, data_byte[4:0]};
					s.min_class = utf8v_pkg::CLS_TWO;
					s.pending   = 2'd1;
				end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
					s.code      = {17'd0, data_byte[3:0]};
					s.min_class = utf8v_pkg::CLS_THREE;
					s.pending   = 2'd2;
				end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
					s.code      = {18'd0, data_byte[2:0]};
					s.min_class = utf8v_pkg::CLS_FOUR;
					s.pending   = 2'd3;
				end else begin
					s.err_seen  = 1'b1;
					s.first_err = utf8v_pkg::ERR_LEAD;
				end
			end else if (data_byte[7:6] != 2'b10) begin
				s.err_seen  = 1'b1;
				s.first_err = utf8v_pkg::ERR_CONT;
				s.pending   = 2'd0;
			end else begin
				s.code    = cp;
				s.pending = cur.pending - 2'd1;
				// Sequence complete: range checks in priority order.
				if (cur.pending == 2'd1) begin
					if (cp < utf8v_pkg::class_minimum(cur.min_class)) begin
						s.err_seen  = 1'b1;
						s.first_err = utf8v_pkg::ERR_OVERLONG;
					end else if (cp > utf8v_pkg::CP_MAX) begin
						s.err_seen  = 1'b1;
						s.first_err = utf8v_pkg::ERR_LARGE;
					end else if (cp >= utf8v_pkg::SURR_LO && cp <= utf8v_pkg::SURR_HI) begin
						s.err_seen  = 1'b1;
						s.first_err = utf8v_pkg::ERR_SURROGATE;
					end
					s.code      = '0;
					s.min_class = utf8v_pkg::CLS_NONE;
				end
			end
		end
	end

	// Verdict on the last byte; the state then returns to reset.
	always_comb begin
		verdict.ok   = 1'b1;
		verdict.kind = utf8v_pkg::ERR_NONE;
		nxt          = s;
		if (is_last) begin
			if (s.err_seen) begin
				verdict.ok   = 1'b0;
				verdict.kind = s.first_err;
			end else if (s.pending != 2'd0) begin
				verdict.ok   = 1'b0;
				verdict.kind = utf8v_pkg::ERR_TRUNC;
			end
			nxt = utf8v_pkg::STATE_RESET;
		end
	end

endmodule

### rtl/utf8v_out_reg.sv
// Result register for the verdict word, with valid/ready toward the consumer.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps

module utf8v_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  utf8v_pkg::verdict_t load_verdict,
	output logic                full,
	input  logic                out_ready,
	output utf8v_pkg::verdict_t verdict
);

	logic                full_q;
	utf8v_pkg::verdict_t verdict_q;

	// Valid flag: set on load, cleared when the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (load) begin
			full_q <= 1'b1;
		end else if (out_ready) begin
			full_q <= 1'b0;
		end
	end

	// Payload holds until the next load.
	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q <= load_verdict;
		end
	end

	assign full    = full_q;
	assign verdict = verdict_q;

endmodule

### rtl/utf8_text_validator_top.sv
// The verdict word is registered and appears in the cycle after the last byte of a buffer is accepted.
// Throughput: one byte per cycle; the decoder state register updates in a single pass.
// A last byte stalls only while a previous verdict is held unread in the result register.
// Reset (arst_n low, asynchronous) clears the decoder state and the result valid flag.
// Top level of the UTF-8 text validator; depends on utf8v_pkg, utf8v_step, utf8v_out_reg.
`timescale 1ns / 1ps

module utf8_text_validator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_valid,
	output logic [2:0] error_kind
);

	utf8v_pkg::dec_state_t state_q;
	utf8v_pkg::dec_state_t state_next;
	utf8v_pkg::verdict_t   verdict_next;
	utf8v_pkg::verdict_t   verdict_out;
	logic                  out_full;
	logic                  in_accept;

	// Only a last byte needs room in the result register.
	assign in_ready  = !is_last || !out_full || out_ready;
	assign in_accept = in_valid && in_ready;

	utf8v_step u_step (
		.cur       (state_q),
		.data_byte (data_byte),
		.is_last   (is_last),
		.nxt       (state_next),
		.verdict   (verdict_next)
	);

	// Decoder state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= utf8v_pkg::STATE_RESET;
		end else if (in_accept) begin
			state_q <= state_next;
		end
	end

	utf8v_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_accept && is_last),
		.load_verdict (verdict_next),
		.full         (out_full),
		.out_ready    (out_ready),
		.verdict      (verdict_out)
	);

	assign out_valid  = out_full;
	assign is_valid   = verdict_out.ok;
	assign error_kind = verdict_out.kind;

endmodule

### rtl/utf8v_checker.sv
// Port-level checks for the UTF-8 text validator, bound to the top level.
// Depends on utf8_text_validator_top_macros.svh and utf8v_pkg.
`timescale 1ns / 1ps
`include "utf8_text_validator_top_macros.svh"

module utf8v_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] data_byte,
	input logic       is_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_valid,
	input logic [2:0] error_kind
);

	// A stalled verdict word keeps its valid and payload.
	`UTF8V_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({is_valid, error_kind}))

	// A passing verdict carries no error class, and a failing one always does.
	`UTF8V_ASSERT_IMP(a_ok_no_kind, out_valid && is_valid, error_kind == utf8v_pkg::ERR_NONE)
	`UTF8V_ASSERT_IMP(a_fail_kind, out_valid && !is_valid, error_kind != utf8v_pkg::ERR_NONE)

	// A NUL as the last byte always fails the buffer in the next cycle.
	`UTF8V_ASSERT_NXT(a_nul_last, in_valid && in_ready && is_last && data_byte == 8'h00, out_valid && !is_valid)

endmodule

bind utf8_text_validator_top utf8v_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.data_byte  (data_byte),
	.is_last    (is_last),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.is_valid   (is_valid),
	.error_kind (error_kind)
);

### tb/testbench.sv
// Self-checking testbench for utf8_text_validator_top: random and directed byte buffers.
// Depends on utf8v_pkg and the validator RTL; a built-in decoder predicts each verdict.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;

	// One byte word as queued for the sender.
	typedef struct {
		logic [7:0] b;
		logic       last;
		logic       drain;
	} text_byte_t;

	// Kinds of character that the generator can place in a buffer.
	typedef enum int {
		CH_ASCII, CH_TWO, CH_THREE, CH_FOUR,
		CH_NUL, CH_BAD_LEAD, CH_BAD_CONT, CH_CUT, CH_OVERLONG, CH_TOO_LARGE, CH_SURROGATE
	} char_kind_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'd0;
	logic       is_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       is_valid;
	logic [2:0] error_kind;

	text_byte_t          text_bytes[$];
	logic [7:0]          draft[$];
	utf8v_pkg::verdict_t verdicts_due[$];
	utf8v_pkg::verdict_t want;
	text_byte_t          next_byte;

	int send_gap = 0;
	int send_calm = 0;
	int stall_left = 0;
	int stall_calm = 0;
	int buffers_closed = 0;
	int verdicts_seen = 0;
	int failures = 0;
	int cycle_count = 0;
	logic long_hold_done = 1'b0;

	// Decoder state of the predictor.
	logic [1:0]  cont_left;
	logic [20:0] cp_acc;
	logic [1:0]  floor_cls;
	logic        err_latched;
	logic [2:0]  err_first;

	utf8_text_validator_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_valid   (is_valid),
		.error_kind (error_kind)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none, some short, a few long, with calm stretches of no idling.
	function automatic int pick_gap(inout int calm_left);
		int r;
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			calm_left = $urandom_range(20, 80);
		if (r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(12, 60);
	endfunction

	// A code point that encodes legally in the given number of bytes.
	function automatic logic [20:0] valid_point(input int len);
		logic [20:0] cp;
		case (len)
			2: cp = 21'($urandom_range('h80, 'h7FF));
			3: begin
				// Skip over the surrogate block.
				cp = 21'($urandom_range('h800, 'hF7FF));
				if (cp >= utf8v_pkg::SURR_LO)
					cp = cp + 21'h800;
			end
			default: cp = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		return cp;
	endfunction

	// Append the plain UTF-8 bit layout of a code point at a forced length.
	task automatic put_code(input logic [20:0] cp, input int len);
		case (len)
			1: draft.push_back({1'b0, cp[6:0]});
			2: begin
				draft.push_back({3'b110, cp[10:6]});
				draft.push_back({2'b10, cp[5:0]});
			end
			3: begin
				draft.push_back({4'b1110, cp[15:12]});
				draft.push_back({2'b10, cp[11:6]});
				draft.push_back({2'b10, cp[5:0]});
			end
			default: begin
				draft.push_back({5'b11110, cp[20:18]});
				draft.push_back({2'b10, cp[17:12]});
				draft.push_back({2'b10, cp[11:6]});
				draft.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// Append one character of the given kind to the draft buffer.
	task automatic add_char(input char_kind_t k);
		int len;
		int at;
		logic [7:0] junk;
		len = $urandom_range(2, 4);
		case (k)
			CH_ASCII:  put_code(21'($urandom_range(1, 127)), 1);
			CH_TWO:    put_code(valid_point(2), 2);
			CH_THREE:  put_code(valid_point(3), 3);
			CH_FOUR:   put_code(valid_point(4), 4);
			CH_NUL:    draft.push_back(8'h00);
			CH_BAD_LEAD: begin
				case ($urandom_range(0, 2))
					0:       draft.push_back(8'($urandom_range('h80, 'hBF)));
					1:       draft.push_back({7'b1100000, 1'($urandom_range(0, 1))});
					default: draft.push_back(8'($urandom_range('hF5, 'hFF)));
				endcase
			end
			CH_BAD_CONT: begin
				// Replace one trailing byte by anything not shaped 10xxxxxx, NUL at times.
				put_code(valid_point(len), len);
				at = draft.size() - $urandom_range(1, len - 1);
				junk = 8'($urandom);
				if (junk[7:6] == 2'b10)
					junk[6] = 1'b1;
				if ($urandom_range(0, 3) == 0)
					junk = 8'h00;
				draft[at] = junk;
			end
			CH_CUT: begin
				put_code(valid_point(len), len);
				repeat ($urandom_range(1, len - 1)) void'(draft.pop_back());
			end
			CH_OVERLONG: begin
				case (len)
					2:       put_code(21'($urandom_range(0, 'h7F)), 2);
					3:       put_code(21'($urandom_range(0, 'h7FF)), 3);
					default: put_code(21'($urandom_range(0, 'hFFFF)), 4);
				endcase
			end
			CH_TOO_LARGE: begin
				if ($urandom_range(0, 3) == 0)
					put_code(21'($urandom_range('h110000, 'h1FFFFF)), 4);
				else
					put_code(21'($urandom_range('h110000, 'h13FFFF)), 4);
			end
			default: put_code(21'($urandom_range('hD800, 'hDFFF)), 3);
		endcase
	endtask

	// Move the draft into the send queue, marking its final byte.
	task automatic flush_buffer(input logic drain);
		for (int i = 0; i < draft.size(); i++)
			text_bytes.push_back('{b: draft[i], last: (i == draft.size() - 1),
				drain: (drain && i == 0)});
		draft.delete();
	endtask

	// Predictor: return the decoder to its idle state.
	task automatic clear_decoder();
		cont_left = 2'd0;
		cp_acc = '0;
		floor_cls = utf8v_pkg::CLS_NONE;
		err_latched = 1'b0;
		err_first = utf8v_pkg::ERR_NONE;
	endtask

	// Predictor: keep only the first error and close any open sequence.
	task automatic note_error(input logic [2:0] kind);
		if (!err_latched) begin
			err_latched = 1'b1;
			err_first = kind;
		end
		cont_left = 2'd0;
	endtask

	// Predictor: fold one byte into the decoder state.
	task automatic absorb_byte(input logic [7:0] b);
		logic [20:0] floor_cp;
		if (err_latched)
			return;
		if (cont_left == 2'd0) begin
			if (b == 8'h00)
				note_error(utf8v_pkg::ERR_NUL);
			else if (b[7] == 1'b0)
				return;
			else if (b >= 8'hC2 && b <= 8'hDF) begin
				cp_acc = {16'd0, b[4:0]};
				floor_cls = utf8v_pkg::CLS_TWO;
				cont_left = 2'd1;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				cp_acc = {17'd0, b[3:0]};
				floor_cls = utf8v_pkg::CLS_THREE;
				cont_left = 2'd2;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				cp_acc = {18'd0, b[2:0]};
				floor_cls = utf8v_pkg::CLS_FOUR;
				cont_left = 2'd3;
			end else
				note_error(utf8v_pkg::ERR_LEAD);
		end else if (b[7:6] != 2'b10)
			note_error(utf8v_pkg::ERR_CONT);
		else begin
			cp_acc = {cp_acc[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				// Range checks in fixed priority once the sequence is complete.
				case (floor_cls)
					utf8v_pkg::CLS_TWO:   floor_cp = 21'h000080;
					utf8v_pkg::CLS_THREE: floor_cp = 21'h000800;
					default:              floor_cp = 21'h010000;
				endcase
				if (cp_acc < floor_cp)
					note_error(utf8v_pkg::ERR_OVERLONG);
				else if (cp_acc > utf8v_pkg::CP_MAX)
					note_error(utf8v_pkg::ERR_LARGE);
				else if (cp_acc >= utf8v_pkg::SURR_LO && cp_acc <= utf8v_pkg::SURR_HI)
					note_error(utf8v_pkg::ERR_SURROGATE);
				cp_acc = '0;
				floor_cls = utf8v_pkg::CLS_NONE;
			end
		end
	endtask

	// Stimulus: directed buffers, then random ones, then wait for the last verdict.
	initial begin : stimulus
		int random_count;
		int n;
		int r;
		char_kind_t k;
		logic mid_drained;
		logic drain;
		random_count = 0;
		mid_drained = 1'b0;

		// Lowest two-byte form after a top ASCII byte, then the highest code point.
		draft = '{8'h7F, 8'hC2, 8'h80};
		flush_buffer(1'b0);
		draft = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
		flush_buffer(1'b0);
		// NUL as a whole buffer.
		draft = '{8'h00};
		flush_buffer(1'b0);
		// Lead 0xC0 is never legal.
		draft = '{8'hC0};
		flush_buffer(1'b0);
		// A stray continuation is reported, and the NUL after it is ignored.
		draft = '{8'h80, 8'h00};
		flush_buffer(1'b0);
		// NUL in a continuation slot is a bad continuation.
		draft = '{8'hC2, 8'h00};
		flush_buffer(1'b0);
		// Three-byte sequence cut off by the end of the buffer.
		draft = '{8'hE0, 8'hA0};
		flush_buffer(1'b0);
		// Overlong, too large and surrogate sequences.
		draft = '{8'hE0, 8'h9F, 8'hBF};
		flush_buffer(1'b0);
		draft = '{8'hF4, 8'h90, 8'h80, 8'h80};
		flush_buffer(1'b0);
		draft = '{8'hED, 8'hA0, 8'h80};
		flush_buffer(1'b0);

		// Random buffers: mostly well-formed text, some errors, some plain noise.
		while (random_count < 620) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) draft.push_back(8'($urandom));
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					r = $urandom_range(0, 99);
					if (r < 35)
						k = CH_ASCII;
					else if (r < 52)
						k = CH_TWO;
					else if (r < 69)
						k = CH_THREE;
					else if (r < 86)
						k = CH_FOUR;
					else
						k = char_kind_t'(int'(CH_NUL) + (r - 86) / 2);
					add_char(k);
					// Usually end right after an error, since later bytes are ignored.
					if (k >= CH_NUL && $urandom_range(0, 3) != 0)
						break;
				end
			end
			if (draft.size() == 0)
				draft.push_back(8'h41);
			drain = (random_count == 0) || (random_count >= 310 && !mid_drained);
			if (random_count >= 310)
				mid_drained = 1'b1;
			random_count += draft.size();
			flush_buffer(drain);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (text_bytes.size() != 0 || in_valid || verdicts_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("utf8_text_validator_top test passed");
		else
			$display("utf8_text_validator_top test failed");
		$finish;
	end

	// Sender: offers one byte word at a time, idles at random, and can wait for a drain.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'd0;
			is_last <= 1'b0;
			send_gap = 0;
			buffers_closed = 0;
		end else begin
			if (in_valid && in_ready && is_last)
				buffers_closed++;
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (text_bytes.size() == 0 ||
						(text_bytes[0].drain && buffers_closed != verdicts_seen)) begin
					in_valid <= 1'b0;
				end else begin
					next_byte = text_bytes.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_byte.b;
					is_last <= next_byte.last;
					send_gap = pick_gap(send_calm);
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off that backs the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (!long_hold_done && verdicts_seen >= 12) begin
				long_hold_done = 1'b1;
				stall_left = 300;
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap(stall_calm);
			end
		end
	end

	// Monitor: checks each verdict word against the oldest prediction, then
	// predicts from the byte word accepted at this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_decoder();
			verdicts_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				verdicts_seen <= verdicts_seen + 1;
				if (verdicts_due.size() == 0) begin
					$display("%0t: unexpected verdict is_valid=%0b error_kind=%0d",
						$realtime, is_valid, error_kind);
					failures++;
				end else begin
					want = verdicts_due.pop_front();
					if (is_valid !== want.ok) begin
						$display("%0t: is_valid expected %0b, got %0b",
							$realtime, want.ok, is_valid);
						failures++;
					end
					if (error_kind !== want.kind) begin
						$display("%0t: error_kind expected %0d, got %0d",
							$realtime, want.kind, error_kind);
						failures++;
					end
				end
			end
			if (in_valid && in_ready) begin
				absorb_byte(data_byte);
				if (is_last) begin
					if (!err_latched && cont_left != 2'd0)
						note_error(utf8v_pkg::ERR_TRUNC);
					verdicts_due.push_back('{ok: !err_latched,
						kind: (err_latched ? err_first : utf8v_pkg::ERR_NONE)});
					clear_decoder();
				end
			end
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("utf8_text_validator_top test failed");
				$finish;
			end
		end
	end

endmodule

### files.f
+incdir+rtl
rtl/utf8v_pkg.sv
rtl/utf8v_step.sv
rtl/utf8v_out_reg.sv
rtl/utf8_text_validator_top.sv
rtl/utf8v_checker.sv
tb/testbench.sv
